[hdl/cioc_pkg.sv]
// Shared types, codes and device evaluation for the console I/O port controller.
package cioc_pkg;

    localparam int LINE_CYCLES_DEF = 228;

    // Bus operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ_A = 2'd1;
    localparam logic [1:0] OP_READ_B = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_EXPORT  = 2'd0;
    localparam logic [1:0] CFG_DEV_A   = 2'd1;
    localparam logic [1:0] CFG_DEV_B   = 2'd2;
    localparam logic [1:0] CFG_MD_MODE = 2'd3;

    // Control byte pin bits
    localparam int PIN_TR_A = 0;
    localparam int PIN_TH_A = 1;
    localparam int PIN_TR_B = 2;
    localparam int PIN_TH_B = 3;

    // Horizontal count table, phaser hit window and idle read constants
    localparam logic [7:0] HC_BASE  = 8'd244;
    localparam logic [7:0] HC_KNEE  = 8'd212;
    localparam logic [7:0] HC_SKIP  = 8'd85;
    localparam logic [8:0] HIT_XWIN = 9'd25;
    localparam logic [9:0] HIT_YWIN = 10'd8;
    localparam logic [7:0] GUN_OFS  = 8'd22;
    localparam logic [7:0] IDLE_BITS = 8'h7F;

    typedef enum logic [1:0] {
        DEV_NONE   = 2'd0,
        DEV_PAD    = 2'd1,
        DEV_PHASER = 2'd2,
        DEV_PADDLE = 2'd3
    } t_dev;

    typedef struct packed {
        logic [7:0] bits;
        logic       flag;
        logic       load;   // first phaser hit: load latch with gun X
    } t_dev_res;

    function automatic t_dev_res dev_eval(
        input t_dev       dev,
        input logic       th_in,
        input logic       tha_high,
        input logic       export_mach,
        input logic       flag,
        input logic [5:0] pad,
        input logic [7:0] analog,
        input logic       hit
    );
        t_dev_res res;
        logic     nf;
        res.bits = IDLE_BITS;
        res.flag = flag;
        res.load = 1'b0;
        nf       = 1'b0;
        unique case (dev)
            DEV_NONE: begin
            end
            DEV_PAD: begin
                res.bits = IDLE_BITS & ~{2'b00, pad};
            end
            DEV_PHASER: begin
                if (th_in) begin
                    if (hit) begin
                        if (!flag) begin
                            res.load = 1'b1;
                            res.flag = 1'b1;
                        end
                        res.bits[6] = 1'b0;
                    end else begin
                        res.flag = 1'b0;
                    end
                end
                if (pad[4]) res.bits[4] = 1'b0;
            end
            DEV_PADDLE: begin
                nf       = export_mach ? ~tha_high : ~flag;
                res.flag = nf;
                if (nf) res.bits = {4'h5, analog[3:0]};
                else    res.bits = {4'h7, analog[7:4]};
                if (pad[4]) res.bits[4] = 1'b0;
            end
            default: begin
            end
        endcase
        return res;
    endfunction

endpackage

[hdl/console_io_port_controller.sv]
// Top level of the console I/O port controller: control byte, H-counter latch, port reads.
//
// One bus access per transfer, one transfer per clock sustained while the
// result side does not stall. An access is captured in an input register,
// evaluated in a single combinational pass (control byte, horizontal-count
// table, device models) and moves on into the result register once that
// register is free or its result transfers. Input ready follows the result
// side: while a result is held, a full input register holds too, and it
// takes a new access in the cycle the held result transfers. State (control
// byte, H latch, device flags) is updated as each access moves into the
// result register, so a following access sees it. Configuration writes take
// effect at once and are meant for an idle block.
module console_io_port_controller #(
    parameter int LINE_CYCLES = cioc_pkg::LINE_CYCLES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [1:0] i_cfg_data,
    // access channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_write_data,
    input  logic [5:0] i_pad_a,
    input  logic [5:0] i_pad_b,
    input  logic [7:0] i_analog_a,
    input  logic [7:0] i_analog_b,
    input  logic       i_reset_button,
    input  logic [7:0] i_line_cycle,
    input  logic [8:0] i_video_line,
    input  logic       i_io_disabled,
    input  logic [7:0] i_unmapped_byte,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic [7:0] o_hcount_latch,
    output logic       o_latch_updated
);

    localparam logic [8:0] LC = 9'(LINE_CYCLES);

    // configuration
    logic          r_export;
    cioc_pkg::t_dev r_dev_a, r_dev_b;
    logic          r_md_mode;

    // state
    logic [7:0] r_ctl, n_ctl;
    logic [7:0] r_hc, n_hc;
    logic       r_flag_a, n_flag_a;
    logic       r_flag_b, n_flag_b;

    // input register
    logic       r_iv;
    logic [1:0] r_op;
    logic [7:0] r_wdata;
    logic [5:0] r_pad_a, r_pad_b;
    logic [7:0] r_an_a, r_an_b;
    logic       r_rst_btn;
    logic [7:0] r_lcyc;
    logic [8:0] r_line;
    logic       r_dis;
    logic [7:0] r_unmap;

    // result register
    logic       r_ov;
    logic [7:0] r_rd, n_rd;
    logic       r_lu, n_lu;

    logic advance;
    logic take;

    assign advance    = !r_ov || i_out_ready;
    assign take       = r_iv && advance;
    assign o_in_ready = !r_iv || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_export  <= 1'b1;
            r_dev_a   <= cioc_pkg::DEV_PAD;
            r_dev_b   <= cioc_pkg::DEV_PAD;
            r_md_mode <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cioc_pkg::CFG_EXPORT:  r_export  <= i_cfg_data[0];
                cioc_pkg::CFG_DEV_A:   r_dev_a   <= cioc_pkg::t_dev'(i_cfg_data);
                cioc_pkg::CFG_DEV_B:   r_dev_b   <= cioc_pkg::t_dev'(i_cfg_data);
                cioc_pkg::CFG_MD_MODE: r_md_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (o_in_ready) begin
            r_iv <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_op      <= i_operation;
            r_wdata   <= i_write_data;
            r_pad_a   <= i_pad_a;
            r_pad_b   <= i_pad_b;
            r_an_a    <= i_analog_a;
            r_an_b    <= i_analog_b;
            r_rst_btn <= i_reset_button;
            r_lcyc    <= i_line_cycle;
            r_line    <= i_video_line;
            r_dis     <= i_io_disabled;
            r_unmap   <= i_unmapped_byte;
        end
    end

    // horizontal count from the line cycle
    logic [8:0] lc_ext;
    logic [8:0] lc_mod;
    logic [7:0] idx;
    logic [7:0] hcount;

    always_comb begin
        lc_ext = {1'b0, r_lcyc};
        lc_mod = (lc_ext >= LC) ? (lc_ext - LC) : lc_ext;
        idx    = lc_mod[7:0];
        hcount = idx + cioc_pkg::HC_BASE - {2'b00, idx[7:2]}
                 - {7'd0, (idx[1:0] == 2'b11)}
                 + ((idx > cioc_pkg::HC_KNEE) ? cioc_pkg::HC_SKIP : 8'd0);
    end

    // phaser hit window, shared by both ports (same gun inputs)
    logic [6:0] gun_x;
    logic       hit;
    always_comb begin
        gun_x = r_an_a[7:1];
        hit = ({2'b00, gun_x} + cioc_pkg::HIT_XWIN > {1'b0, hcount})
           && ({2'b00, gun_x} < {1'b0, hcount} + cioc_pkg::HIT_XWIN)
           && ({2'b00, r_an_b} + cioc_pkg::HIT_YWIN > {1'b0, r_line})
           && ({2'b00, r_an_b} < {1'b0, r_line} + cioc_pkg::HIT_YWIN);
    end

    // pin levels under the current control byte
    logic [3:0] pin_in;
    logic [3:0] pin_hi;
    assign pin_in = r_ctl[3:0];
    assign pin_hi = r_ctl[3:0] | ({4{r_export}} & r_ctl[7:4]);

    cioc_pkg::t_dev_res res_a, res_b;
    always_comb begin
        res_a = cioc_pkg::dev_eval(r_dev_a, pin_in[cioc_pkg::PIN_TH_A],
                                   pin_hi[cioc_pkg::PIN_TH_A], r_export, r_flag_a,
                                   r_pad_a, r_an_a, hit);
        res_b = cioc_pkg::dev_eval(r_dev_b, pin_in[cioc_pkg::PIN_TH_B],
                                   pin_hi[cioc_pkg::PIN_TH_A], r_export, r_flag_b,
                                   r_pad_b, r_an_b, hit);
    end

    always_comb begin
        n_ctl    = r_ctl;
        n_hc     = r_hc;
        n_flag_a = r_flag_a;
        n_flag_b = r_flag_b;
        n_rd     = 8'hFF;
        n_lu     = 1'b0;
        case (r_op)
            cioc_pkg::OP_WRITE: begin
                // rising TH-A latches the H counter
                if (r_wdata[cioc_pkg::PIN_TH_A] && !pin_hi[cioc_pkg::PIN_TH_A]) begin
                    n_hc = hcount;
                    n_lu = 1'b1;
                end
                n_ctl = r_wdata;
            end
            cioc_pkg::OP_READ_A, cioc_pkg::OP_READ_B: begin
                if (r_dis) begin
                    n_rd = r_unmap;
                end else begin
                    n_flag_a = res_a.flag;
                    n_flag_b = res_b.flag;
                    if (res_a.load || res_b.load) begin
                        n_hc = {1'b0, gun_x} + cioc_pkg::GUN_OFS;
                        n_lu = 1'b1;
                    end
                    if (r_op == cioc_pkg::OP_READ_A) begin
                        n_rd = {res_b.bits[1:0], res_a.bits[5:0]};
                        if (!pin_in[cioc_pkg::PIN_TR_A]) n_rd[5] = pin_hi[cioc_pkg::PIN_TR_A];
                    end else begin
                        n_rd = {res_b.bits[6], res_a.bits[6], 2'b11, res_b.bits[5:2]};
                        if (!pin_in[cioc_pkg::PIN_TR_B]) n_rd[3] = pin_hi[cioc_pkg::PIN_TR_B];
                        if (!pin_in[cioc_pkg::PIN_TH_A]) n_rd[6] = pin_hi[cioc_pkg::PIN_TH_A];
                        if (!pin_in[cioc_pkg::PIN_TH_B]) n_rd[7] = pin_hi[cioc_pkg::PIN_TH_B];
                        if (r_rst_btn) n_rd[4] = 1'b0;
                        if (r_md_mode) n_rd[5] = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= 8'hFF;
            r_hc     <= 8'd0;
            r_flag_a <= 1'b0;
            r_flag_b <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            if (advance) r_ov <= r_iv;
            if (take) begin
                r_ctl    <= n_ctl;
                r_hc     <= n_hc;
                r_flag_a <= n_flag_a;
                r_flag_b <= n_flag_b;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_rd <= n_rd;
            r_lu <= n_lu;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_read_data     = r_rd;
    assign o_hcount_latch  = r_hc;
    assign o_latch_updated = r_lu;

endmodule
